// File: rtl/lafs_pkg.sv
// Shared types, constants and codes of the LED frame sequencer.
package lafs_pkg;

  localparam int DEF_MAX_LEDS  = 256;
  localparam int HALF_SLOTS    = 24;
  localparam int BYTES_PER_LED = 3;
  localparam int BYTE_W        = 8;
  localparam int ROW_W         = BYTE_W * BYTES_PER_LED;
  localparam int SLOT_CNT_W    = $clog2(HALF_SLOTS);
  localparam int ZERO_BURSTS   = 2;

  localparam int OP_W          = 3;
  localparam int LED_IDX_W     = 8;
  localparam int CHAN_W        = 2;
  localparam int LED_COUNT_W   = 9;
  localparam int LATCH_W       = 8;
  localparam int DUTY_W        = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [LED_COUNT_W-1:0] RST_LED_COUNT     = 9'd1;
  localparam logic [LATCH_W-1:0]     RST_LATCH_REFILLS = 8'd10;
  localparam logic [DUTY_W-1:0]      RST_DUTY_ONE      = 16'd60;
  localparam logic [DUTY_W-1:0]      RST_DUTY_ZERO     = 16'd30;

  typedef enum logic [OP_W-1:0] {
    OP_REFILL  = 3'd0,
    OP_WR_CHAN = 3'd1,
    OP_WR_PIX  = 3'd2,
    OP_BEGIN   = 3'd3,
    OP_COMMIT  = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LED_COUNT     = 2'd0,
    CFG_LATCH_REFILLS = 2'd1,
    CFG_DUTY_ONE      = 2'd2,
    CFG_DUTY_ZERO     = 2'd3
  } cfg_idx_t;

  // What an accepted item turns into.
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_ZERO  = 3'd1,
    KIND_DATA  = 3'd2,
    KIND_ACK   = 3'd3,
    KIND_SWEEP = 3'd4
  } item_kind_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic shift;
    logic sweep_run;
  } lafs_cmd_t;

  typedef struct packed {
    item_kind_t kind;
    logic       last_slot;
    logic       sweep_done;
  } lafs_stat_t;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [LED_IDX_W-1:0] led_index;
    logic [CHAN_W-1:0]    channel;
    logic [BYTE_W-1:0]    value;
    logic [BYTE_W-1:0]    red;
    logic [BYTE_W-1:0]    green;
    logic [BYTE_W-1:0]    blue;
  } lafs_item_t;

  typedef struct packed {
    logic              is_slot;
    logic [DUTY_W-1:0] slot_value;
    logic              last;
    logic              status;
  } lafs_result_t;

endpackage

// File: rtl/lafs_if.sv
// Handshake channel interfaces for items, results and configuration writes.
interface lafs_in_if;
  import lafs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [LED_IDX_W-1:0] led_index;
  logic [CHAN_W-1:0]    channel;
  logic [BYTE_W-1:0]    value;
  logic [BYTE_W-1:0]    red;
  logic [BYTE_W-1:0]    green;
  logic [BYTE_W-1:0]    blue;
  modport source (output valid, operation, led_index, channel, value, red, green, blue,
                  input ready);
  modport sink (input valid, operation, led_index, channel, value, red, green, blue,
                output ready);
endinterface

interface lafs_out_if;
  import lafs_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_slot;
  logic [DUTY_W-1:0] slot_value;
  logic              last;
  logic              status;
  modport source (output valid, is_slot, slot_value, last, status, input ready);
  modport sink (input valid, is_slot, slot_value, last, status, output ready);
endinterface

interface lafs_cfg_if;
  import lafs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/lafs_dp.sv
// Datapath: pixel stores, frame mode state, slot shifter and configuration registers.
module lafs_dp #(
  parameter int MAX_LEDS = lafs_pkg::DEF_MAX_LEDS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lafs_pkg::lafs_cmd_t             cmd,
  output lafs_pkg::lafs_stat_t            stat,
  input  lafs_pkg::lafs_item_t            item,
  input  logic                            cfg_we,
  input  logic [lafs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lafs_pkg::CFG_DATA_W-1:0] cfg_data,
  output lafs_pkg::lafs_result_t          res
);
  import lafs_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = ($clog2(MAX_LEDS + 1) > LED_COUNT_W) ? $clog2(MAX_LEDS + 1) : LED_COUNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEDS);

  typedef enum logic [1:0] {
    MODE_LATCH = 2'd0,
    MODE_IDLE  = 2'd1,
    MODE_DATA  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SW_INIT  = 2'd0,
    SW_CLEAR = 2'd1,
    SW_COPY  = 2'd2
  } sweep_t;

  // Configuration registers.
  logic [LED_COUNT_W-1:0] led_count;
  logic [LATCH_W-1:0]     latch_refills;
  logic [DUTY_W-1:0]      duty_one;
  logic [DUTY_W-1:0]      duty_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count     <= RST_LED_COUNT;
      latch_refills <= RST_LATCH_REFILLS;
      duty_one      <= RST_DUTY_ONE;
      duty_zero     <= RST_DUTY_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LED_COUNT:     led_count     <= cfg_data[LED_COUNT_W-1:0];
        CFG_LATCH_REFILLS: latch_refills <= cfg_data[LATCH_W-1:0];
        CFG_DUTY_ONE:      duty_one      <= cfg_data[DUTY_W-1:0];
        CFG_DUTY_ZERO:     duty_zero     <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] led_count_x;
  logic [CW-1:0] eff;
  logic          addr_ok;

  assign led_count_x = CW'(led_count);
  assign eff         = (led_count_x > MAX_CNT) ? MAX_CNT : led_count_x;
  assign addr_ok     = CW'(item.led_index) < eff;

  // Frame mode state.
  mode_t             mode, mode_next;
  logic [AW-1:0]     cur, cur_next;
  logic [LATCH_W-1:0] latch_count, latch_count_next;
  logic [1:0]        zhs, zhs_next;
  logic              dirty, dirty_next;
  logic              swap_pending, swap_pending_next;
  logic              front_sel, front_sel_next;
  logic [LATCH_W-1:0] lc_inc;
  logic [CW-1:0]     cur_inc;
  logic              boundary;
  item_kind_t        kind;

  always_comb begin
    kind = KIND_ACK;
    unique case (item.operation) inside
      OP_REFILL: begin
        if (mode == MODE_DATA) begin
          kind = KIND_DATA;
        end else if (mode == MODE_LATCH && zhs < 2'(ZERO_BURSTS)) begin
          kind = KIND_ZERO;
        end else begin
          kind = KIND_NONE;
        end
      end
      OP_BEGIN, OP_CLEAR: kind = (eff != '0) ? KIND_SWEEP : KIND_ACK;
      default: kind = KIND_ACK;
    endcase
  end

  always_comb begin
    mode_next         = mode;
    cur_next          = cur;
    latch_count_next  = latch_count;
    zhs_next          = zhs;
    dirty_next        = dirty;
    swap_pending_next = swap_pending;
    front_sel_next    = front_sel;
    boundary          = 1'b0;
    lc_inc  = (latch_count == '1) ? latch_count : latch_count + LATCH_W'(1);
    cur_inc = CW'(cur) + CW'(1);
    if (cmd.accept) begin
      unique case (item.operation) inside
        OP_REFILL: begin
          unique case (mode)
            MODE_LATCH: begin
              if (zhs < 2'(ZERO_BURSTS)) begin
                zhs_next = zhs + 2'd1;
              end
              latch_count_next = lc_inc;
              if (lc_inc >= latch_refills) begin
                cur_next = '0;
                boundary = 1'b1;
              end
            end
            MODE_IDLE: boundary = 1'b1;
            MODE_DATA: begin
              if (cur_inc >= eff) begin
                cur_next         = '0;
                zhs_next         = '0;
                latch_count_next = '0;
                mode_next        = MODE_LATCH;
              end else begin
                cur_next = cur_inc[AW-1:0];
              end
            end
            default: ;
          endcase
        end
        OP_COMMIT, OP_CLEAR: begin
          swap_pending_next = 1'b1;
          dirty_next        = 1'b1;
        end
        default: ;
      endcase
      // Frame boundary: a pending commit swaps the stores and starts a frame; otherwise latch mode falls back to idle.
      if (boundary) begin
        if (dirty || swap_pending) begin
          if (swap_pending) begin
            front_sel_next    = ~front_sel;
            swap_pending_next = 1'b0;
          end
          dirty_next = 1'b0;
          mode_next  = MODE_DATA;
        end else if (mode == MODE_LATCH) begin
          mode_next = MODE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_LATCH;
      cur          <= '0;
      latch_count  <= '0;
      zhs          <= 2'(ZERO_BURSTS);
      dirty        <= 1'b0;
      swap_pending <= 1'b0;
      front_sel    <= 1'b0;
    end else begin
      mode         <= mode_next;
      cur          <= cur_next;
      latch_count  <= latch_count_next;
      zhs          <= zhs_next;
      dirty        <= dirty_next;
      swap_pending <= swap_pending_next;
      front_sel    <= front_sel_next;
    end
  end

  // Sweep engine for the power-up clear, the clear operation and the frame copy.
  sweep_t        skind;
  logic [CW-1:0] sidx;
  logic [CW-1:0] bound;
  logic          issue;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;

  assign bound = (skind == SW_INIT) ? MAX_CNT : eff;
  assign issue = cmd.sweep_run && (sidx < bound);

  always_ff @(posedge clk) begin
    if (rst) begin
      skind   <= SW_INIT;
      sidx    <= '0;
      wr_pend <= 1'b0;
    end else begin
      if (cmd.accept && kind == KIND_SWEEP) begin
        skind <= (item.operation == OP_BEGIN) ? SW_COPY : SW_CLEAR;
        sidx  <= '0;
      end else if (issue) begin
        sidx <= sidx + CW'(1);
      end
      wr_pend <= issue && (skind == SW_COPY);
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= sidx[AW-1:0];
  end

  // Pixel stores, one row of three bytes per LED, byte zero in the top lane.
  logic [ROW_W-1:0]         store_a [MAX_LEDS];
  logic [ROW_W-1:0]         store_b [MAX_LEDS];
  logic [ROW_W-1:0]         rd_a, rd_b, front_rd;
  logic [AW-1:0]            raddr;
  logic [BYTES_PER_LED-1:0] back_we, we_a, we_b;
  logic [AW-1:0]            back_addr, addr_a, addr_b;
  logic [ROW_W-1:0]         back_data, data_a, data_b;
  logic                     clr;

  assign front_rd = front_sel ? rd_b : rd_a;
  assign raddr    = issue ? sidx[AW-1:0] : cur;
  assign clr      = issue && (skind != SW_COPY);

  always_comb begin
    back_we   = '0;
    back_addr = AW'(item.led_index);
    back_data = {BYTES_PER_LED{item.value}};
    if (wr_pend) begin
      back_we   = '1;
      back_addr = wr_addr;
      back_data = front_rd;
    end else if (cmd.accept && addr_ok) begin
      if (item.operation == OP_WR_PIX) begin
        back_we   = '1;
        back_data = {item.green, item.red, item.blue};
      end else if (item.operation == OP_WR_CHAN &&
                   item.channel < CHAN_W'(BYTES_PER_LED)) begin
        back_we[item.channel] = 1'b1;
      end
    end
  end

  assign we_a   = clr ? '1 : (front_sel ? back_we : '0);
  assign we_b   = clr ? '1 : (front_sel ? '0 : back_we);
  assign addr_a = clr ? sidx[AW-1:0] : back_addr;
  assign addr_b = clr ? sidx[AW-1:0] : back_addr;
  assign data_a = clr ? '0 : back_data;
  assign data_b = clr ? '0 : back_data;

  always_ff @(posedge clk) begin
    for (int l = 0; l < BYTES_PER_LED; l++) begin
      if (we_a[l]) begin
        store_a[addr_a][ROW_W-1-BYTE_W*l -: BYTE_W] <= data_a[ROW_W-1-BYTE_W*l -: BYTE_W];
      end
    end
    rd_a <= store_a[raddr];
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < BYTES_PER_LED; l++) begin
      if (we_b[l]) begin
        store_b[addr_b][ROW_W-1-BYTE_W*l -: BYTE_W] <= data_b[ROW_W-1-BYTE_W*l -: BYTE_W];
      end
    end
    rd_b <= store_b[raddr];
  end

  // Slot shifter and result register.
  logic [ROW_W-1:0]      sh;
  logic [SLOT_CNT_W-1:0] cnt;
  logic                  slot_q, zero_q, st_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.accept || cmd.load) begin
      cnt <= '0;
    end else if (cmd.shift) begin
      cnt <= cnt + SLOT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_q <= (item.operation == OP_REFILL);
      zero_q <= (kind == KIND_ZERO);
      st_q   <= (item.operation == OP_WR_CHAN || item.operation == OP_WR_PIX) && !addr_ok;
      sh     <= '0;
    end else if (cmd.load) begin
      sh <= front_rd;
    end else if (cmd.shift) begin
      sh <= {sh[ROW_W-2:0], 1'b0};
    end
  end

  assign stat.kind       = kind;
  assign stat.last_slot  = (cnt == SLOT_CNT_W'(HALF_SLOTS - 1));
  assign stat.sweep_done = !(sidx < bound) && !wr_pend;

  assign res.is_slot    = slot_q;
  assign res.slot_value = (slot_q && !zero_q) ? (sh[ROW_W-1] ? duty_one : duty_zero) : '0;
  assign res.last       = !slot_q || stat.last_slot;
  assign res.status     = st_q;

endmodule

// File: rtl/lafs_ctrl.sv
// Controller state machine that sequences items, sweeps and result transfers.
module lafs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lafs_pkg::lafs_stat_t stat,
  output lafs_pkg::lafs_cmd_t  cmd
);
  import lafs_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EMIT  = 6'b001000,
    S_ACK   = 6'b010000,
    S_SWEEP = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (stat.kind)
            KIND_NONE:  state_next = S_IDLE;
            KIND_ZERO:  state_next = S_EMIT;
            KIND_DATA:  state_next = S_READ;
            KIND_SWEEP: state_next = S_SWEEP;
            default:    state_next = S_ACK;
          endcase
        end
      end
      S_READ: begin
        cmd.load   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift = 1'b1;
          if (stat.last_slot) begin
            state_next = S_IDLE;
          end
        end
      end
      S_ACK: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_done) begin
          state_next = S_ACK;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && stat.kind != KIND_NONE) |=> !in_ready)
    else $error("new item taken before results of the previous one");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_ready && stat.last_slot) |=> in_ready)
    else $error("not ready after the final slot transfer");

  a_load_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (out_valid && !stat.last_slot))
    else $error("slot burst did not start after the store read");
`endif

endmodule

// File: rtl/addressable_led_frame_sequencer_core.sv
// Top level of the double-buffered addressable LED frame sequencer.
//
// The block takes one item at a time on the item channel and returns its results on
// the result channel; both are valid/ready channels and a transfer happens on a
// rising edge with valid and ready high. Registers are written on the cfg channel,
// whose ready is always high; write them only while the block is idle.
// A refill in data mode reads one LED row from the front store and then sends
// 24 slot results, one per cycle while the receiver is ready. A refill in latch
// mode may send zero slots instead, or nothing at all. Writes and commits offer
// their acknowledgement in the cycle after the transfer. Begin frame and clear
// sweep the stores one LED row per cycle. After reset both pixel stores are
// cleared by a pass over all MAX_LEDS rows during which no item is taken;
// configuration writes are taken throughout.
// When the receiver stalls, the pending result holds and the item channel stays
// not ready until every result of the current item has gone.
module addressable_led_frame_sequencer_core #(
  parameter int MAX_LEDS = lafs_pkg::DEF_MAX_LEDS
) (
  input logic        clk,
  input logic        rst,
  lafs_in_if.sink    item,
  lafs_out_if.source result,
  lafs_cfg_if.sink   cfg
);
  import lafs_pkg::*;

  lafs_cmd_t    cmd;
  lafs_stat_t   stat;
  lafs_item_t   item_bus;
  lafs_result_t res;
  logic         in_ready;
  logic         out_valid;

  // The configuration port never back-pressures.
  assign cfg.ready = 1'b1;

  assign item_bus.operation = item.operation;
  assign item_bus.led_index = item.led_index;
  assign item_bus.channel   = item.channel;
  assign item_bus.value     = item.value;
  assign item_bus.red       = item.red;
  assign item_bus.green     = item.green;
  assign item_bus.blue      = item.blue;

  assign item.ready = in_ready;

  lafs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lafs_dp #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item_bus),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .res       (res)
  );

  // Result fields come straight from the datapath's result registers.
  assign result.valid      = out_valid;
  assign result.is_slot    = res.is_slot;
  assign result.slot_value = res.slot_value;
  assign result.last       = res.last;
  assign result.status     = res.status;

endmodule

// File: tb/tb_addressable_led_frame_sequencer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the addressable LED frame sequencer core.
module tb_addressable_led_frame_sequencer_core;
  import lafs_pkg::*;

  localparam int STORE_LEN     = DEF_MAX_LEDS * BYTES_PER_LED;
  // Margin after the last result before the block counts as idle. A refill that
  // produces nothing finishes with its own transfer, so this is ample.
  localparam int SETTLE_CYCLES = 30;
  // Length of the long receiver hold-off used to back the block up.
  localparam int HOLD_CYCLES   = 400;
  // Operation codes the block does not define; it must acknowledge them and do nothing.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Mode of the waveform generator as tracked by the predictor.
  typedef enum logic [1:0] {
    SEQ_LATCH,
    SEQ_IDLE,
    SEQ_DATA
  } seq_mode_t;

  logic clk;
  logic rst;

  lafs_in_if  in_ch();
  lafs_out_if out_ch();
  lafs_cfg_if cfg_ch();

  addressable_led_frame_sequencer_core uut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch),
    .cfg    (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: both pixel stores, the frame machine and the registers.
  // pix[front_sel] is the store being shown; the other one takes pixel writes.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]      pix [2][STORE_LEN];
  logic                   front_sel;
  logic                   dirty_q;
  logic                   swap_q;
  seq_mode_t              seq_mode;
  int                     cur_led;
  int                     latch_cnt;
  int                     zero_bursts;
  logic [LED_COUNT_W-1:0] led_count_r;
  logic [LATCH_W-1:0]     latch_refills_r;
  logic [DUTY_W-1:0]      duty_one_r;
  logic [DUTY_W-1:0]      duty_zero_r;

  // Results still owed by the block, oldest first.
  lafs_result_t pending_results[$];

  int items_sent;
  int results_seen;
  int cfg_writes;
  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  // ---------------------------------------------------------------------------
  // Clock, time limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous limit for the slowest correct run, including the store clearing
  // pass after reset.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The effective LED count saturates at the size of the stores.
  function automatic int active_leds();
    return (led_count_r > DEF_MAX_LEDS) ? DEF_MAX_LEDS : int'(led_count_r);
  endfunction

  function automatic void expect_result(logic slot, logic [DUTY_W-1:0] val, logic lst,
                                        logic st);
    lafs_result_t r;
    r.is_slot    = slot;
    r.slot_value = val;
    r.last       = lst;
    r.status     = st;
    pending_results.push_back(r);
  endfunction

  // A frame boundary starts a new frame only when there is something new to
  // show; a pending commit also swaps the stores here. With nothing new, latch
  // mode falls back to idle.
  function automatic void reach_frame_boundary();
    if (dirty_q || swap_q) begin
      if (swap_q) begin
        front_sel = ~front_sel;
        swap_q    = 1'b0;
      end
      dirty_q  = 1'b0;
      seq_mode = SEQ_DATA;
    end else if (seq_mode == SEQ_LATCH) begin
      seq_mode = SEQ_IDLE;
    end
  endfunction

  // Slots produced by one refill request.
  function automatic void predict_refill();
    int                led;
    int                n;
    logic [BYTE_W-1:0] b;
    case (seq_mode)
      SEQ_LATCH: begin
        // The first two refills of a latch period send a half buffer of zero
        // slots; later ones only count toward the end of the latch period.
        if (zero_bursts < ZERO_BURSTS) begin
          for (int i = 0; i < HALF_SLOTS; i++)
            expect_result(1'b1, '0, i == HALF_SLOTS - 1, 1'b0);
          zero_bursts++;
        end
        if (latch_cnt < 255) latch_cnt++;
        if (latch_cnt >= latch_refills_r) begin
          cur_led = 0;
          reach_frame_boundary();
        end
      end
      SEQ_IDLE: begin
        reach_frame_boundary();
      end
      default: begin
        // One LED per refill: its three stored bytes, each MSB first.
        led = (cur_led < DEF_MAX_LEDS) ? cur_led : 0;
        n   = 0;
        for (int c = 0; c < BYTES_PER_LED; c++) begin
          b = pix[front_sel][BYTES_PER_LED * led + c];
          for (int k = BYTE_W - 1; k >= 0; k--) begin
            expect_result(1'b1, b[k] ? duty_one_r : duty_zero_r, n == HALF_SLOTS - 1, 1'b0);
            n++;
          end
        end
        // With a zero LED count, LED 0 still goes out once per frame.
        cur_led = led + 1;
        if (cur_led >= active_leds()) begin
          cur_led     = 0;
          zero_bursts = 0;
          latch_cnt   = 0;
          seq_mode    = SEQ_LATCH;
        end
      end
    endcase
  endfunction

  // Works out every result of one accepted item and queues it.
  function automatic void predict_led_results(lafs_item_t it);
    int   n;
    int   base;
    logic bk;
    logic st;
    n    = active_leds();
    base = BYTES_PER_LED * it.led_index;
    bk   = ~front_sel;
    st   = 1'b0;
    if (it.operation == OP_REFILL) begin
      predict_refill();
      return;
    end
    case (it.operation)
      OP_WR_CHAN, OP_WR_PIX: begin
        if (it.led_index >= n) begin
          st = 1'b1;
        end else if (it.operation == OP_WR_CHAN) begin
          // Channel three names no byte and is dropped without an error.
          if (it.channel < BYTES_PER_LED) pix[bk][base + it.channel] = it.value;
        end else begin
          // Stores keep the chain's green, red, blue byte order.
          pix[bk][base]     = it.green;
          pix[bk][base + 1] = it.red;
          pix[bk][base + 2] = it.blue;
        end
      end
      OP_BEGIN: begin
        for (int i = 0; i < BYTES_PER_LED * n; i++) pix[bk][i] = pix[front_sel][i];
      end
      OP_COMMIT: begin
        swap_q  = 1'b1;
        dirty_q = 1'b1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < BYTES_PER_LED * n; i++) begin
          pix[0][i] = '0;
          pix[1][i] = '0;
        end
        dirty_q = 1'b1;
        swap_q  = 1'b1;
      end
      default: begin
      end
    endcase
    expect_result(1'b0, '0, 1'b1, st);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every transfer on the result channel is compared with
  // the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void note_failure(string what, lafs_result_t want, lafs_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected slot=%0b value=%0d last=%0b status=%0b, got slot=%0b value=%0d last=%0b status=%0b",
               $realtime, what, want.is_slot, want.slot_value, want.last, want.status,
               got.is_slot, got.slot_value, got.last, got.status);
  endfunction

  always @(posedge clk) begin
    lafs_result_t got;
    lafs_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.is_slot    = out_ch.is_slot;
      got.slot_value = out_ch.slot_value;
      got.last       = out_ch.last;
      got.status     = out_ch.status;
      results_seen++;
      if (pending_results.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.is_slot !== want.is_slot || got.slot_value !== want.slot_value ||
            got.last !== want.last || got.status !== want.status)
          note_failure("result mismatch", want, got);
      end
    end
  end

  // Receiver: random stalls at the current rate, or a long hold-off that
  // counts itself down once a test arms it.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic lafs_item_t make_item(logic [OP_W-1:0] op,
                                           logic [LED_IDX_W-1:0] idx = '0,
                                           logic [CHAN_W-1:0] ch = '0,
                                           logic [BYTE_W-1:0] val = '0,
                                           logic [BYTE_W-1:0] r = '0,
                                           logic [BYTE_W-1:0] g = '0,
                                           logic [BYTE_W-1:0] b = '0);
    lafs_item_t it;
    it.operation = op;
    it.led_index = idx;
    it.channel   = ch;
    it.value     = val;
    it.red       = r;
    it.green     = g;
    it.blue      = b;
    return it;
  endfunction

  // With pixel_write set the item is a pixel or channel write aimed mostly at a
  // real LED; otherwise any operation code, undefined ones included.
  function automatic lafs_item_t random_item(bit pixel_write);
    lafs_item_t it;
    int         pick;
    int         n;
    n    = active_leds();
    pick = $urandom_range(99);
    if (pixel_write)
      it.operation = pick[0] ? OP_WR_PIX : OP_WR_CHAN;
    else if (pick < 50)
      it.operation = OP_REFILL;
    else if (pick < 62)
      it.operation = OP_WR_PIX;
    else if (pick < 74)
      it.operation = OP_WR_CHAN;
    else if (pick < 82)
      it.operation = OP_COMMIT;
    else if (pick < 88)
      it.operation = OP_BEGIN;
    else if (pick < 93)
      it.operation = OP_CLEAR;
    else if (pick < 97)
      it.operation = OP_SPARE_LO;
    else
      it.operation = OP_SPARE_HI;
    if (n > 0 && $urandom_range(9) < 8)
      it.led_index = LED_IDX_W'($urandom_range(n - 1));
    else
      it.led_index = LED_IDX_W'($urandom_range(255));
    it.channel = CHAN_W'($urandom_range(3));
    it.value   = BYTE_W'($urandom);
    it.red     = BYTE_W'($urandom);
    it.green   = BYTE_W'($urandom);
    it.blue    = BYTE_W'($urandom);
    return it;
  endfunction

  // Offers one item, with random idle cycles first, and predicts it once the
  // transfer has happened. Valid stays high afterwards so back-to-back items
  // follow without a gap; whoever pauses the sender lowers it.
  task automatic send_item(lafs_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= it.operation;
    in_ch.led_index <= it.led_index;
    in_ch.channel   <= it.channel;
    in_ch.value     <= it.value;
    in_ch.red       <= it.red;
    in_ch.green     <= it.green;
    in_ch.blue      <= it.blue;
    do @(posedge clk); while (!in_ch.ready);
    predict_led_results(it);
    items_sent++;
  endtask

  task automatic send_refills(int count);
    repeat (count) send_item(make_item(OP_REFILL));
  endtask

  // Stops offering items and waits until every owed result has arrived, then
  // lets the block settle so a refill that produced nothing is finished too.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_LED_COUNT:     led_count_r     = data[LED_COUNT_W-1:0];
      CFG_LATCH_REFILLS: latch_refills_r = data[LATCH_W-1:0];
      CFG_DUTY_ONE:      duty_one_r      = data[DUTY_W-1:0];
      default:           duty_zero_r     = data[DUTY_W-1:0];
    endcase
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operation under the reset register values: a pixel write, a write
  // past the chain, channel writes including the unused channel three, both
  // undefined codes, then a commit that takes effect when the ten-refill latch
  // period ends. The following refills show LED 0 and then the two zero half
  // buffers of the next latch period. Begin frame and clear close the test.
  task automatic test_operations_at_reset_values();
    send_item(make_item(OP_WR_PIX, 8'd0, 2'd0, 8'd0, 8'hFF, 8'h00, 8'hA5));
    send_item(make_item(OP_WR_PIX, 8'hFF, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(OP_WR_CHAN, 8'd0, 2'd1, 8'h5A));
    send_item(make_item(OP_WR_CHAN, 8'd0, 2'd3, 8'hFF));
    send_item(make_item(OP_SPARE_LO, 8'd0));
    send_item(make_item(OP_SPARE_HI, 8'hFF, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(OP_COMMIT));
    send_refills(13);
    send_item(make_item(OP_BEGIN));
    send_item(make_item(OP_CLEAR));
    wait_until_drained();
  endtask

  // Register extremes: a zero LED count (every write is out of range, LED 0
  // still goes out once per frame), a zero latch period, duty values at both
  // ends, then the full chain and a count above it that must saturate.
  task automatic test_register_extremes();
    write_reg(CFG_LED_COUNT, 16'd0);
    write_reg(CFG_LATCH_REFILLS, 16'd0);
    write_reg(CFG_DUTY_ONE, 16'hFFFF);
    write_reg(CFG_DUTY_ZERO, 16'h0000);
    send_item(make_item(OP_WR_PIX, 8'd0, 2'd0, 8'd0, 8'h11, 8'h22, 8'h33));
    send_item(make_item(OP_WR_CHAN, 8'd0, 2'd2, 8'h44));
    send_item(make_item(OP_CLEAR));
    send_refills(5);
    wait_until_drained();

    write_reg(CFG_LED_COUNT, 16'd256);
    send_item(make_item(OP_WR_PIX, 8'hFF, 2'd0, 8'd0, 8'hC3, 8'h3C, 8'h81));
    send_item(make_item(OP_WR_CHAN, 8'hFF, 2'd2, 8'h7E));
    wait_until_drained();

    write_reg(CFG_LED_COUNT, 16'd511);
    send_item(make_item(OP_BEGIN));
    send_item(make_item(OP_WR_CHAN, 8'h80, 2'd0, 8'hAA));
    wait_until_drained();
  endtask

  // A long latch period. Most refills here produce nothing; commits keep new
  // frames coming so the period is entered and left.
  task automatic test_long_latch_period();
    write_reg(CFG_LED_COUNT, 16'd2);
    write_reg(CFG_LATCH_REFILLS, 16'd30);
    write_reg(CFG_DUTY_ONE, 16'h8001);
    write_reg(CFG_DUTY_ZERO, 16'h7FFE);
    send_item(make_item(OP_WR_PIX, 8'd1, 2'd0, 8'd0, 8'h0F, 8'hF0, 8'h99));
    send_item(make_item(OP_COMMIT));
    send_refills(34);
    send_item(make_item(OP_COMMIT));
    send_refills(34);
    wait_until_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // data refills, so the block backs up and stops taking items. Afterwards
  // the sender pauses until every result has come before going on.
  task automatic test_receiver_hold_off();
    write_reg(CFG_LED_COUNT, 16'd3);
    write_reg(CFG_LATCH_REFILLS, 16'd1);
    write_reg(CFG_DUTY_ONE, CFG_DATA_W'($urandom));
    write_reg(CFG_DUTY_ZERO, CFG_DATA_W'($urandom));
    send_item(make_item(OP_WR_PIX, 8'd2, 2'd0, 8'd0, 8'h5A, 8'hA5, 8'hF0));
    send_item(make_item(OP_COMMIT));
    hold_left = HOLD_CYCLES;
    send_refills(12);
    wait_until_drained();
    send_item(make_item(OP_WR_CHAN, 8'd1, 2'd1, 8'h3C));
    send_refills(4);
    wait_until_drained();
  endtask

  // Random traffic under one idling profile. Most of it is frame updates: a
  // few pixel writes, a commit and two to eight refills; the
  // rest is any item at all, undefined codes and stray indexes included.
  task automatic run_traffic_phase(int send_pct, int stall_pct, int item_goal);
    int phase_base;
    write_reg(CFG_LED_COUNT, CFG_DATA_W'($urandom_range(6, 1)));
    write_reg(CFG_LATCH_REFILLS, CFG_DATA_W'($urandom_range(4, 1)));
    write_reg(CFG_DUTY_ONE, CFG_DATA_W'($urandom));
    write_reg(CFG_DUTY_ZERO, CFG_DATA_W'($urandom));
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    phase_base     = items_sent;
    while (items_sent - phase_base < item_goal) begin
      if ($urandom_range(9) < 7) begin
        repeat ($urandom_range(4, 1)) send_item(random_item(1'b1));
        send_item(make_item(OP_COMMIT));
        send_refills($urandom_range(8, 2));
      end else begin
        send_item(random_item(1'b0));
      end
    end
    wait_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 20);
    run_traffic_phase(67, 0, 20);
    run_traffic_phase(0, 67, 20);
    run_traffic_phase(35, 35, 20);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.led_index = '0;
    in_ch.channel   = '0;
    in_ch.value     = '0;
    in_ch.red       = '0;
    in_ch.green     = '0;
    in_ch.blue      = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_LED_COUNT;
    cfg_ch.data     = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_left       = 0;
    items_sent      = 0;
    results_seen    = 0;
    cfg_writes      = 0;
    fail_count      = 0;

    // Predictor starts from the reset state of the block.
    for (int i = 0; i < STORE_LEN; i++) begin
      pix[0][i] = '0;
      pix[1][i] = '0;
    end
    front_sel       = 1'b0;
    dirty_q         = 1'b0;
    swap_q          = 1'b0;
    seq_mode        = SEQ_LATCH;
    cur_led         = 0;
    latch_cnt       = 0;
    zero_bursts     = ZERO_BURSTS;
    led_count_r     = RST_LED_COUNT;
    latch_refills_r = RST_LATCH_REFILLS;
    duty_one_r      = RST_DUTY_ONE;
    duty_zero_r     = RST_DUTY_ZERO;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_operations_at_reset_values();
    test_register_extremes();
    test_long_latch_period();
    test_receiver_hold_off();
    test_random_traffic();

    wait_until_drained();
    if (pending_results.size() != 0) fail_count++;

    $display("Covered all operations, register extremes, a long latch period and a long");
    $display("receiver hold-off: %0d items, %0d results, %0d register writes, %0d failures",
             items_sent, results_seen, cfg_writes, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
